// File: rtl/pfa_pkg.sv
// Package for the polar force accumulator: widths, CORDIC constants, the
// arctangent table and the controller/datapath command types.
// No dependencies.
`default_nettype none

package pfa_pkg;

    // Default iteration count of each CORDIC pass.
    localparam int CORDIC_ITERATIONS_DEF = 16;

    // Field widths.
    localparam int MAG_W  = 24;
    localparam int HEAD_W = 16;
    localparam int FORCE_W = 24;

    // Vector datapath: Q12.12 with 8 guard bits, plus headroom for CORDIC gain.
    localparam int GUARD_BITS = 8;
    localparam int VEC_W      = 38;
    // Angle accumulator: degrees with 16 fraction bits.
    localparam int ANG_W      = 27;
    // Table index width (up to 32 iterations).
    localparam int STEP_W     = 5;

    // Multiplier: a 24-bit operand times the fixed inverse gain.
    localparam int MUL_A_W   = 24;
    localparam int MUL_P_W   = 48;
    localparam int SPLIT_W   = 18;

    localparam logic [MUL_A_W-1:0] INV_GAIN_Q24 = 24'd10188014;

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] HEAD_MAX_A = ANG_W'(23040);
    localparam logic signed [ANG_W-1:0] HEAD_MIN_A = -ANG_W'(23040);
    localparam logic signed [ANG_W-1:0] HEAD_ROUND = ANG_W'(256);
    localparam logic [MAG_W-1:0] MAG_MAX = 24'hFFFFFF;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT_INIT,
        S_ROT,
        S_ADD,
        S_VEC_INIT,
        S_VEC,
        S_MUL_LO,
        S_MUL_HI,
        S_FINISH,
        S_CLEAR
    } ctrl_state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_ROT_INIT,
        DP_ROT_STEP,
        DP_ADD_FORCE,
        DP_VEC_INIT,
        DP_VEC_STEP,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_FINISH,
        DP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    // round(atan(2^-i) * 180/pi * 2^16)
    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = ANG_W'(2949120);
                5'd1:    v = ANG_W'(1740967);
                5'd2:    v = ANG_W'(919879);
                5'd3:    v = ANG_W'(466945);
                5'd4:    v = ANG_W'(234379);
                5'd5:    v = ANG_W'(117304);
                5'd6:    v = ANG_W'(58666);
                5'd7:    v = ANG_W'(29335);
                5'd8:    v = ANG_W'(14668);
                5'd9:    v = ANG_W'(7334);
                5'd10:   v = ANG_W'(3667);
                5'd11:   v = ANG_W'(1833);
                5'd12:   v = ANG_W'(917);
                5'd13:   v = ANG_W'(458);
                5'd14:   v = ANG_W'(229);
                5'd15:   v = ANG_W'(115);
                5'd16:   v = ANG_W'(57);
                5'd17:   v = ANG_W'(29);
                5'd18:   v = ANG_W'(14);
                5'd19:   v = ANG_W'(7);
                5'd20:   v = ANG_W'(4);
                5'd21:   v = ANG_W'(2);
                5'd22:   v = ANG_W'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/pfa_ctrl.sv
// Controller for the polar force accumulator: sequences both CORDIC passes,
// the gain multiply and the result handshake. Depends on pfa_pkg.
`default_nettype none

module pfa_ctrl #(
    parameter int CORDIC_ITERATIONS = pfa_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            opcode,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pfa_pkg::dp_cmd_t     cmd
);
    import pfa_pkg::*;

    localparam int CNT_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_ITERATIONS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             can_write;
    logic             do_write;

    // The result slot is free when empty or being drained this cycle.
    assign can_write = !out_valid_reg || out_ready;
    assign do_write  = (state_reg inside {S_FINISH, S_CLEAR}) && can_write;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = opcode ? S_CLEAR : S_ROT_INIT;
                end
            end
            S_ROT_INIT: state_next = S_ROT;
            S_ROT:
            begin
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ADD:      state_next = S_VEC_INIT;
            S_VEC_INIT: state_next = S_VEC;
            S_VEC:
            begin
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL_LO;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_FINISH;
            S_FINISH, S_CLEAR:
            begin
                if (can_write)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.op   = DP_NOP;
        cmd.step = STEP_W'(cnt_reg);
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = DP_CAPTURE;
                end
            end
            S_ROT_INIT: cmd.op = DP_ROT_INIT;
            S_ROT:      cmd.op = DP_ROT_STEP;
            S_ADD:      cmd.op = DP_ADD_FORCE;
            S_VEC_INIT: cmd.op = DP_VEC_INIT;
            S_VEC:      cmd.op = DP_VEC_STEP;
            S_MUL_LO:   cmd.op = DP_MUL_LO;
            S_MUL_HI:   cmd.op = DP_MUL_HI;
            S_FINISH:   cmd.op = can_write ? DP_FINISH : DP_NOP;
            S_CLEAR:    cmd.op = can_write ? DP_CLEAR : DP_NOP;
            default:    cmd.op = DP_NOP;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (do_write)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfa_datapath.sv
// Datapath for the polar force accumulator: CORDIC vector/angle registers,
// shared inverse-gain multiplier, stored polar state. Depends on pfa_pkg.
`default_nettype none

module pfa_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pfa_pkg::dp_cmd_t                     cmd,
    input  wire logic signed [pfa_pkg::FORCE_W-1:0]   force_x,
    input  wire logic signed [pfa_pkg::FORCE_W-1:0]   force_y,
    output logic        [pfa_pkg::MAG_W-1:0]          magnitude,
    output logic signed [pfa_pkg::HEAD_W-1:0]         heading,
    output logic                                      saturated
);
    import pfa_pkg::*;

    logic signed [FORCE_W-1:0] fx_reg, fy_reg;
    logic signed [VEC_W-1:0]   x_reg, x_next;
    logic signed [VEC_W-1:0]   y_reg, y_next;
    logic signed [ANG_W-1:0]   z_reg, z_next;
    logic [MUL_P_W-1:0]        mul_reg, lo_reg;
    logic                      zero_reg, zero_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic signed [HEAD_W-1:0]  head_reg, head_next;
    logic                      sat_reg, sat_next;

    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_P_W-1:0]        mul_prod;
    logic signed [VEC_W-1:0]   dx, dy;
    logic signed [ANG_W-1:0]   atan_v;
    logic signed [VEC_W-1:0]   x0;
    logic signed [ANG_W-1:0]   z0;
    logic [VEC_W-1:0]          t;
    logic [63:0]               mag_sum;
    logic [31:0]               magv;
    logic signed [ANG_W-1:0]   h_full;

    assign dx     = y_reg >>> cmd.step;
    assign dy     = x_reg >>> cmd.step;
    assign atan_v = atan_deg(cmd.step);

    // Start vector: floor(mag * invK / 2^16), always below 2^32.
    assign x0 = $signed({{(VEC_W-32){1'b0}}, mul_reg[47:16]});
    assign z0 = $signed({{(ANG_W-HEAD_W-9){head_reg[HEAD_W-1]}}, head_reg, 9'b0});

    // Clamp a negative vectoring result to zero before the gain multiply.
    assign t = x_reg[VEC_W-1] ? '0 : x_reg;

    always_comb
    begin
        case (cmd.op)
            DP_CAPTURE: mul_a = mag_reg;
            DP_MUL_LO:  mul_a = MUL_A_W'(t[SPLIT_W-1:0]);
            DP_MUL_HI:  mul_a = MUL_A_W'(t[2*SPLIT_W-1:SPLIT_W]);
            default:    mul_a = '0;
        endcase
    end

    assign mul_prod = mul_a * INV_GAIN_Q24;

    // (hi * 2^18 + lo) * invK + 2^31, then take bits above 32.
    assign mag_sum = ({16'b0, mul_reg} << SPLIT_W) + {16'b0, lo_reg} + 64'h8000_0000;
    assign magv    = mag_sum[63:32];
    assign h_full  = (z_reg + HEAD_ROUND) >>> 9;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        mag_next  = mag_reg;
        head_next = head_reg;
        sat_next  = sat_reg;
        case (cmd.op)
            DP_ROT_INIT:
            begin
                y_next = '0;
                if (z0 > DEG90)
                begin
                    z_next = z0 - DEG180;
                    x_next = -x0;
                end
                else if (z0 < -DEG90)
                begin
                    z_next = z0 + DEG180;
                    x_next = -x0;
                end
                else
                begin
                    z_next = z0;
                    x_next = x0;
                end
            end
            DP_ROT_STEP:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_v;
                end
            end
            DP_ADD_FORCE:
            begin
                x_next = x_reg + $signed({{(VEC_W-FORCE_W-GUARD_BITS){fx_reg[FORCE_W-1]}},
                                          fx_reg, {GUARD_BITS{1'b0}}});
                y_next = y_reg + $signed({{(VEC_W-FORCE_W-GUARD_BITS){fy_reg[FORCE_W-1]}},
                                          fy_reg, {GUARD_BITS{1'b0}}});
            end
            DP_VEC_INIT:
            begin
                zero_next = (x_reg == '0) && (y_reg == '0);
                if (x_reg[VEC_W-1])
                begin
                    z_next = y_reg[VEC_W-1] ? -DEG180 : DEG180;
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                else
                begin
                    z_next = '0;
                end
            end
            DP_VEC_STEP:
            begin
                if (y_reg[VEC_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_v;
                end
            end
            DP_FINISH:
            begin
                if (zero_reg)
                begin
                    mag_next  = '0;
                    head_next = '0;
                    sat_next  = 1'b0;
                end
                else
                begin
                    sat_next  = (magv[31:MAG_W] != '0);
                    mag_next  = (magv[31:MAG_W] != '0) ? MAG_MAX : magv[MAG_W-1:0];
                    if (h_full > HEAD_MAX_A)
                    begin
                        head_next = HEAD_W'(HEAD_MAX_A);
                    end
                    else if (h_full < HEAD_MIN_A)
                    begin
                        head_next = HEAD_W'(HEAD_MIN_A);
                    end
                    else
                    begin
                        head_next = h_full[HEAD_W-1:0];
                    end
                end
            end
            DP_CLEAR:
            begin
                mag_next = '0;
                sat_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        if (cmd.op == DP_CAPTURE)
        begin
            fx_reg <= force_x;
            fy_reg <= force_y;
        end
        if (cmd.op inside {DP_CAPTURE, DP_MUL_LO, DP_MUL_HI})
        begin
            mul_reg <= mul_prod;
        end
        if (cmd.op == DP_MUL_HI)
        begin
            lo_reg <= mul_reg;
        end
    end

    // Stored polar state, also the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg  <= '0;
            head_reg <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            mag_reg  <= mag_next;
            head_reg <= head_next;
            sat_reg  <= sat_next;
        end
    end

    assign magnitude = mag_reg;
    assign heading   = head_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// File: rtl/polar_force_accumulator.sv
// Top level of the polar force accumulator: joins controller and datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
`default_nettype none

//  channel | signals                          | direction | transaction
//  --------+----------------------------------+-----------+----------------------------
//  input   | in_valid/in_ready, opcode,       | in        | one apply or clear item
//          | force_x, force_y                 |           |
//  output  | out_valid/out_ready, magnitude,  | out       | one result per input item
//          | heading, saturated               |           |
//
// In an apply transaction the two CORDIC passes run one iteration per cycle
// on a shared shift/add unit, and the gain multiply uses one 24-bit
// multiplier three times.
// Reset zeroes the stored magnitude and heading and empties the result slot.
// A new item is accepted while the previous result waits; the block only
// holds in its final step while the result slot is still occupied.

module polar_force_accumulator #(
    parameter int CORDIC_ITERATIONS = pfa_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 opcode,
    input  wire logic signed [pfa_pkg::FORCE_W-1:0]   force_x,
    input  wire logic signed [pfa_pkg::FORCE_W-1:0]   force_y,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic        [pfa_pkg::MAG_W-1:0]          magnitude,
    output logic signed [pfa_pkg::HEAD_W-1:0]         heading,
    output logic                                      saturated
);
    import pfa_pkg::*;

    dp_cmd_t cmd;

    // Sequence the item: accept, rotate, add force, vector, gain, write back.
    pfa_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold the polar state; the stored values double as the result fields,
    // since they only change when the result slot is free.
    pfa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .force_x   (force_x),
        .force_y   (force_y),
        .magnitude (magnitude),
        .heading   (heading),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for polar_force_accumulator: a queue-fed driver,
// a monitor with a bit-exact CORDIC predictor and a result scoreboard.
// Depends on pfa_pkg and the polar_force_accumulator RTL.
`timescale 1ns / 100ps

module tb;

    import pfa_pkg::*;

    // Opcode values of the input channel.
    localparam logic OP_APPLY = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Predictor constants: Q12.12 vector with guard bits, angles in deg * 2^16.
    localparam int     CORDIC_STEPS = CORDIC_ITERATIONS_DEF;
    localparam longint INV_GAIN     = longint'(INV_GAIN_Q24);
    localparam longint ANGLE_90     = 64'sd90 * 65536;
    localparam longint ANGLE_180    = 64'sd180 * 65536;
    localparam longint HEAD_LIMIT   = 23040;
    localparam longint MAG_LIMIT    = longint'(MAG_MAX);

    // Drain time at the end of the run, with some slack beyond the apply latency.
    localparam int DRAIN_CYCLES   = 2 * CORDIC_STEPS + 24;
    localparam int RANDOM_ITEMS   = 550;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_ITEM   = 120;
    localparam int PHASE1_START   = 190;
    localparam int PHASE2_START   = 380;
    localparam int MAX_PRINTED    = 40;

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = 24'sh7FFFFF;
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = 24'sh800000;

    typedef struct {
        logic                      op;
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
    } force_item_t;

    typedef struct {
        logic        [MAG_W-1:0]  mag;
        logic signed [HEAD_W-1:0] head;
        logic                     sat;
    } polar_result_t;

    // Arctangent steps in degrees * 2^16; entries past the table act as zero.
    longint arctan_q16 [0:31] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic                      opcode    = OP_APPLY;
    logic signed [FORCE_W-1:0] force_x   = '0;
    logic signed [FORCE_W-1:0] force_y   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic        [MAG_W-1:0]   magnitude;
    logic signed [HEAD_W-1:0]  heading;
    logic                      saturated;

    // Predicted accumulator state, mirrors the block's stored polar state.
    logic        [MAG_W-1:0]  acc_mag  = '0;
    logic signed [HEAD_W-1:0] acc_head = '0;

    force_item_t   pending_items[$];
    polar_result_t expected_polar[$];

    int n_offered     = 0;   // transactions accepted on the input (driver side)
    int n_results     = 0;
    int n_clears      = 0;
    int n_saturated   = 0;
    int n_mismatches  = 0;
    int hold_cnt      = 0;
    bit hold_used     = 1'b0;

    polar_force_accumulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .force_x   (force_x),
        .force_y   (force_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .magnitude (magnitude),
        .heading   (heading),
        .saturated (saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (n_mismatches < MAX_PRINTED)
            $display("tb: mismatch in %s at result %0d: got %0d, expected %0d",
                     what, n_results, got, want);
        n_mismatches++;
    endtask

    task automatic queue_item(input logic op, input logic signed [FORCE_W-1:0] fx,
                              input logic signed [FORCE_W-1:0] fy);
        force_item_t it;
        it.op = op;
        it.fx = fx;
        it.fy = fy;
        pending_items.push_back(it);
    endtask

    function automatic logic signed [FORCE_W-1:0] pick_force();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return FORCE_W'(int'($urandom_range(8191)) - 4096);
        if (r < 45)
        begin
            case ($urandom_range(4))
                0:       return FORCE_MAX;
                1:       return FORCE_MIN;
                2:       return '0;
                3:       return 24'sd1;
                default: return -24'sd1;
            endcase
        end
        return FORCE_W'($urandom());
    endfunction

    function automatic bit idle_draw(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Idling schedule by progress: sender-light, receiver-light, then none.
    function automatic int sender_idle_pct();
        if (n_offered < PHASE1_START)
            return 36;
        if (n_offered < PHASE2_START)
            return 78;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_offered < PHASE1_START)
            return 78;
        if (n_offered < PHASE2_START)
            return 36;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: rotate the stored polar vector to x/y, add the force,
    // vector it back to magnitude/heading. Advances acc_mag/acc_head.
    // ------------------------------------------------------------------
    task automatic advance_polar(input force_item_t it, output polar_result_t r);
        longint x, y, z, dx, dy, fx, fy, m, h;
        longint unsigned prod;
        logic sat;
        sat = 1'b0;
        if (it.op == OP_CLEAR)
        begin
            // Wall hit: drop the magnitude, keep the heading.
            acc_mag = '0;
        end
        else
        begin
            m = acc_mag;
            x = (m * INV_GAIN) >>> (24 - GUARD_BITS);
            y = 0;
            z = acc_head;
            z = z * 512;
            // Fold headings outside +-90 degrees into the CORDIC range.
            if (z > ANGLE_90)
            begin
                z = z - ANGLE_180;
                x = -x;
            end
            else if (z < -ANGLE_90)
            begin
                z = z + ANGLE_180;
                x = -x;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_q16[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_q16[i];
                end
            end

            fx = it.fx;
            fy = it.fy;
            x = x + fx * 256;
            y = y + fy * 256;

            if (x == 0 && y == 0)
            begin
                m = 0;
                h = 0;
            end
            else
            begin
                z = 0;
                // Left half plane: mirror the vector and start from +-180.
                if (x < 0)
                begin
                    z = (y >= 0) ? ANGLE_180 : -ANGLE_180;
                    x = -x;
                    y = -y;
                end
                for (int i = 0; i < CORDIC_STEPS; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y < 0)
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - arctan_q16[i];
                    end
                    else
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + arctan_q16[i];
                    end
                end
                prod = (x < 0) ? 0 : x;
                prod = prod * INV_GAIN + 64'h8000_0000;
                m = longint'(prod >> 32);
                h = (z + 256) >>> 9;
            end
            if (m > MAG_LIMIT)
            begin
                m = MAG_LIMIT;
                sat = 1'b1;
            end
            if (h > HEAD_LIMIT)
                h = HEAD_LIMIT;
            if (h < -HEAD_LIMIT)
                h = -HEAD_LIMIT;
            acc_mag  = m[MAG_W-1:0];
            acc_head = h[HEAD_W-1:0];
        end
        r.mag  = acc_mag;
        r.head = acc_head;
        r.sat  = sat;
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items, hold each until the transaction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                n_offered <= n_offered + 1;
            if (!in_valid || in_ready)
            begin
                // Keep offering during the receiver hold-off so the block backs up.
                if (pending_items.size() != 0 &&
                    (hold_cnt != 0 || !idle_draw(sender_idle_pct())))
                begin
                    in_valid <= 1'b1;
                    opcode   <= pending_items[0].op;
                    force_x  <= pending_items[0].fx;
                    force_y  <= pending_items[0].fy;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, partway through the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt != 0)
                hold_cnt <= hold_cnt - 1;
            else if (!hold_used && n_offered == HOLD_AT_ITEM)
            begin
                hold_cnt  <= HOLD_CYCLES;
                hold_used <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results against the oldest prediction, then predict
    // for the input transaction of this edge, then choose out_ready.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        polar_result_t want;
        force_item_t   seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (saturated)
                    n_saturated++;
                if (expected_polar.size() == 0)
                begin
                    report_mismatch("result with none pending", magnitude, -1);
                end
                else
                begin
                    want = expected_polar.pop_front();
                    if (magnitude !== want.mag)
                        report_mismatch("magnitude", magnitude, want.mag);
                    if (heading !== want.head)
                        report_mismatch("heading", heading, want.head);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                end
            end
            if (in_valid && in_ready)
            begin
                seen.op = opcode;
                seen.fx = force_x;
                seen.fy = force_y;
                if (opcode == OP_CLEAR)
                    n_clears++;
                advance_polar(seen, want);
                expected_polar.push_back(want);
            end
            out_ready <= (hold_cnt == 0) && !idle_draw(receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        // Zero sum straight out of reset, then simple axis-aligned pushes.
        queue_item(OP_APPLY, 24'sd0, 24'sd0);
        queue_item(OP_APPLY, 24'sd4096, 24'sd0);
        queue_item(OP_APPLY, 24'sd0, 24'sd4096);
        // Pull into the left half plane, both signs of y.
        queue_item(OP_APPLY, -24'sd16384, 24'sd0);
        queue_item(OP_APPLY, 24'sd0, -24'sd16384);
        queue_item(OP_APPLY, FORCE_MIN, 24'sd0);
        queue_item(OP_APPLY, 24'sd0, FORCE_MAX);
        // Clear with busy force fields, then a zero vector through both passes.
        queue_item(OP_CLEAR, FORCE_MAX, FORCE_MIN);
        queue_item(OP_APPLY, 24'sd0, 24'sd0);
        // Heading exactly at 180, then a stored heading past 90 degrees.
        queue_item(OP_APPLY, -24'sd4096, 24'sd0);
        queue_item(OP_APPLY, -24'sd4096, -24'sd1);
        queue_item(OP_APPLY, 24'sd1, 24'sd1);
        // Drive the magnitude into saturation and keep it there.
        queue_item(OP_APPLY, FORCE_MAX, FORCE_MAX);
        queue_item(OP_APPLY, FORCE_MAX, FORCE_MAX);
        queue_item(OP_APPLY, FORCE_MAX, FORCE_MAX);
        queue_item(OP_APPLY, FORCE_MIN, FORCE_MIN);
        queue_item(OP_CLEAR, FORCE_MIN, FORCE_MIN);
        // Near -180 after rounding, where the heading clamp applies.
        queue_item(OP_APPLY, FORCE_MIN, -24'sd1);
        queue_item(OP_APPLY, -24'sd1, 24'sd0);
        queue_item(OP_APPLY, FORCE_MIN, FORCE_MAX);
        queue_item(OP_CLEAR, 24'sd0, 24'sd0);
        queue_item(OP_APPLY, 24'sd0, FORCE_MIN);
        queue_item(OP_APPLY, FORCE_MAX, FORCE_MIN);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            r = $urandom_range(99);
            if (r < 12)
                queue_item(OP_CLEAR, FORCE_W'($urandom()), FORCE_W'($urandom()));
            else if (r < 18)
                queue_item(OP_APPLY, 24'sd0, 24'sd0);
            else
                queue_item(OP_APPLY, pick_force(), pick_force());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so the driver's updates have settled.
        while (pending_items.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_polar.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tb: %0d input transactions (%0d clears), %0d results checked,",
                 n_offered, n_clears, n_results);
        $display("tb: %0d saturated results, %0d mismatches", n_saturated, n_mismatches);
        if (n_mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
